FILE: rtl/point_set_half_diameter_top_defines.svh
// Assertion shorthands for the point set half diameter block.
// Both forms sample on clk and are switched off while rst_n is low.
`ifndef POINT_SET_HALF_DIAMETER_TOP_DEFINES_SVH
`define POINT_SET_HALF_DIAMETER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

    localparam int POINT_W        = 24;
    localparam int RADIUS_W       = 26;
    localparam int AXES           = 3;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;
    localparam int FIFO_DEPTH     = 4;
    localparam int MIN_SET_POINTS = 2;

    // How the front end classified one request.
    typedef struct packed {
        logic store_en;
        logic last;
        logic dropped;
    } psd_flags_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_COL,
        ST_DRAIN,
        ST_ROOT,
        ST_OUT
    } psd_state_t;

endpackage
`default_nettype wire

FILE: rtl/point_set_half_diameter_top.sv
// Loading: one point request per cycle; the input stalls only when the four-entry queue is full.
// After the final point leaves the queue, the pair scan reads one point per cycle from the
// point store through its single read port, and the square root resolves one bit per cycle.
// Reset (rst_n low, asynchronous) clears counters, flags, the queue and the scan state;
// the point store is not cleared and needs no initialization pass.
`default_nettype none
module point_set_half_diameter_top import psd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [POINT_W-1:0] point_x,
    input  logic signed [POINT_W-1:0] point_y,
    input  logic signed [POINT_W-1:0] point_z,
    input  logic                      last_point,
    input  logic                      point_valid,
    output logic                      point_stall,
    output logic [RADIUS_W-1:0]       radius,
    output logic                      too_few,
    output logic                      overflowed,
    output logic                      result_valid,
    input  logic                      result_stall
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ENT_W = $bits(psd_flags_t) + CNT_W + AW + AXES * COORD_BITS;

    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             fifo_full;
    logic             pop;
    logic [ENT_W-1:0] pop_data;
    logic             not_empty;

    psd_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ENT_W      (ENT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .last_point  (last_point),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_data   (push_data)
    );

    psd_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    psd_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ENT_W      (ENT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ent_valid    (not_empty),
        .ent_data     (pop_data),
        .ent_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .radius       (radius),
        .too_few      (too_few),
        .overflowed   (overflowed)
    );

endmodule
`default_nettype wire

FILE: rtl/psd_isqrt.sv
`default_nettype none
module psd_isqrt import psd_pkg::*;
#(
    parameter int ROOT_W = COORD_BITS_DEF + 1,
    parameter int IN_W   = 2 * ROOT_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic [IN_W-1:0]   n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // One root bit per cycle: bring down the next two bits of the radicand
    // and try to subtract 4*root+1.
    always_comb
    begin
        rem_shift = {rem_reg[ROOT_W-1:0], n_reg[IN_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[IN_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

FILE: rtl/psd_fifo.sv
`default_nettype none
module psd_fifo import psd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = slot_reg[rd_ptr_reg];
    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign not_empty = (fill_reg != '0);

endmodule
`default_nettype wire

FILE: rtl/psd_front.sv
`default_nettype none
module psd_front import psd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENT_W      = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [POINT_W-1:0] point_x,
    input  logic signed [POINT_W-1:0] point_y,
    input  logic signed [POINT_W-1:0] point_z,
    input  logic                      last_point,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  logic                      fifo_full,
    output logic                      push,
    output logic [ENT_W-1:0]          push_data
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    logic [CW-1:0]    cz;
    logic [CNT_W-1:0] count_after;
    psd_flags_t       flags;

    // Coordinates are two's complement in their low COORD_BITS bits.
    if (COORD_BITS <= POINT_W)
    begin : g_narrow
        assign cx = point_x[CW-1:0];
        assign cy = point_y[CW-1:0];
        assign cz = point_z[CW-1:0];
    end
    else
    begin : g_wide
        assign cx = {{(CW - POINT_W){point_x[POINT_W-1]}}, point_x};
        assign cy = {{(CW - POINT_W){point_y[POINT_W-1]}}, point_y};
        assign cz = {{(CW - POINT_W){point_z[POINT_W-1]}}, point_z};
    end

    assign point_stall = fifo_full;
    assign push        = point_valid && !fifo_full;

    always_comb
    begin
        flags.store_en = (count_reg < CNT_W'(MAX_POINTS));
        flags.last     = last_point;
        flags.dropped  = dropped_reg || !flags.store_en;
        count_after    = flags.store_en ? (count_reg + CNT_W'(1)) : count_reg;

        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (push)
        begin
            if (last_point)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                count_next   = count_after;
                dropped_next = flags.dropped;
            end
        end
    end

    // On a final point the count field carries the number of points of the set that were stored.
    assign push_data = {flags, count_after, count_reg[AW-1:0], cz, cy, cx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/psd_back.sv
`default_nettype none
module psd_back import psd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENT_W      = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ent_valid,
    input  logic [ENT_W-1:0]    ent_data,
    output logic                ent_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [RADIUS_W-1:0] radius,
    output logic                too_few,
    output logic                overflowed
);

    localparam int CW     = COORD_BITS;
    localparam int PT_W   = AXES * CW;
    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int FLAG_W = $bits(psd_flags_t);
    localparam int SQ_W   = 2 * CW;
    localparam int SUM_W  = 2 * CW + 2;
    localparam int ROOT_W = CW + 1;

    logic [PT_W-1:0] mem [MAX_POINTS];

    psd_state_t state_reg;
    psd_state_t state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             drop_reg;
    logic             drop_next;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;
    logic             latch_reg;
    logic             rd_valid_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [SUM_W-1:0] max_reg;
    logic             max_clear;

    logic [PT_W-1:0]  rd_q_reg;
    logic [PT_W-1:0]  pi_reg;
    logic [CW-1:0]    mag_reg  [AXES];
    logic [CW-1:0]    mag_next [AXES];
    logic [SQ_W-1:0]  sq_reg   [AXES];
    logic [SUM_W-1:0] sum_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_next;
    logic                too_few_reg;
    logic                too_few_next;
    logic                ovf_reg;
    logic                ovf_next;

    psd_flags_t       ent_flags;
    logic [CNT_W-1:0] ent_count;
    logic [AW-1:0]    ent_addr;
    logic [PT_W-1:0]  ent_point;
    logic [AW-1:0]    rd_addr;
    logic             root_start;
    logic             root_done;
    logic [ROOT_W-1:0] root;
    logic [RADIUS_W-1:0] root_sat;
    logic             few;
    logic             pipe_busy;
    logic signed [CW:0] diff_w [AXES];

    assign ent_flags = psd_flags_t'(ent_data[ENT_W-1 -: FLAG_W]);
    assign ent_count = ent_data[PT_W + AW +: CNT_W];
    assign ent_addr  = ent_data[PT_W +: AW];
    assign ent_point = ent_data[PT_W-1:0];

    assign few       = (cnt_reg < CNT_W'(MIN_SET_POINTS));
    assign pipe_busy = rd_valid_reg || v1_reg || v2_reg || v3_reg;
    assign rd_addr   = (state_reg == ST_ROW) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    // Point store: written while a set loads, read once per row and once per pair during the scan.
    always_ff @(posedge clk)
    begin
        if (ent_pop && ent_flags.store_en)
        begin
            mem[ent_addr] <= ent_point;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ent_pop        = 1'b0;
        max_clear      = 1'b0;
        root_start     = 1'b0;
        out_valid_next = out_valid_reg;
        radius_next    = radius_reg;
        too_few_next   = too_few_reg;
        ovf_next       = ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (ent_valid)
                begin
                    ent_pop = 1'b1;
                    if (ent_flags.last)
                    begin
                        cnt_next   = ent_count;
                        drop_next  = ent_flags.dropped;
                        i_next     = '0;
                        max_clear  = 1'b1;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                // The read of point i goes out here; its row then streams every j > i.
                if ((i_reg + CNT_W'(1)) < cnt_reg)
                begin
                    j_next     = i_reg + CNT_W'(1);
                    state_next = ST_COL;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_COL:
            begin
                if ((j_reg + CNT_W'(1)) == cnt_reg)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    out_valid_next = 1'b1;
                    radius_next    = few ? '0 : root_sat;
                    too_few_next   = few;
                    ovf_next       = drop_reg;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            latch_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            latch_reg     <= (state_reg == ST_ROW) && (state_next == ST_COL);
            rd_valid_reg  <= (state_reg == ST_COL);
            v1_reg        <= rd_valid_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
            if (max_clear)
            begin
                max_reg <= '0;
            end
            else if (v3_reg && (sum_reg > max_reg))
            begin
                max_reg <= sum_reg;
            end
        end
    end

    // Absolute differences against the row point; the magnitude always fits CW bits.
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            diff_w[k]   = $signed({pi_reg[k*CW + CW - 1], pi_reg[k*CW +: CW]})
                        - $signed({rd_q_reg[k*CW + CW - 1], rd_q_reg[k*CW +: CW]});
            mag_next[k] = diff_w[k][CW] ? CW'(-diff_w[k]) : CW'(diff_w[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_reg)
        begin
            pi_reg <= rd_q_reg;
        end
        for (int k = 0; k < AXES; k++)
        begin
            mag_reg[k] <= mag_next[k];
            sq_reg[k]  <= mag_reg[k] * mag_reg[k];
        end
        sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        radius_reg  <= radius_next;
        too_few_reg <= too_few_next;
        ovf_reg     <= ovf_next;
    end

    psd_isqrt #(
        .ROOT_W (ROOT_W),
        .IN_W   (SUM_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (max_reg),
        .done  (root_done),
        .root  (root)
    );

    if (ROOT_W > RADIUS_W)
    begin : g_sat
        assign root_sat = (|root[ROOT_W-1:RADIUS_W]) ? '1 : root[RADIUS_W-1:0];
    end
    else
    begin : g_ext
        assign root_sat = RADIUS_W'(root);
    end

    assign result_valid = out_valid_reg;
    assign radius       = radius_reg;
    assign too_few      = too_few_reg;
    assign overflowed   = ovf_reg;

endmodule
`default_nettype wire

FILE: rtl/psd_checker.sv
`default_nettype none
`include "point_set_half_diameter_top_defines.svh"
module psd_checker import psd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      last_point,
    input logic                      point_valid,
    input logic                      point_stall,
    input logic [RADIUS_W-1:0]       radius,
    input logic                      too_few,
    input logic                      overflowed,
    input logic                      result_valid,
    input logic                      result_stall
);

    localparam int PEND_W = 4;

    logic [PEND_W-1:0] pending_reg;
    logic              set_done;
    logic              out_taken;

    assign set_done  = point_valid && !point_stall && last_point;
    assign out_taken = result_valid && !result_stall;

    // Number of finished sets whose result has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (set_done && !out_taken && (pending_reg != '1))
        begin
            pending_reg <= pending_reg + PEND_W'(1);
        end
        else if (!set_done && out_taken && (pending_reg != '0))
        begin
            pending_reg <= pending_reg - PEND_W'(1);
        end
    end

    `PSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(radius) && $stable(too_few) && $stable(overflowed),
        "stalled result changed")
    `PSD_ASSERT_SAME(a_too_few_zero, result_valid && too_few, radius == '0,
        "too_few result with nonzero radius")
    `PSD_ASSERT_SAME(a_result_has_set, result_valid, pending_reg != '0,
        "result without a completed point set")
    `PSD_ASSERT_NEXT(a_single_result, out_taken, !result_valid,
        "second result right after a taken one")

endmodule

bind point_set_half_diameter_top psd_checker u_psd_checker (.*);
`default_nettype wire
